/* src/sequence_reorder_buffer_unit_macros.svh */
// Assertion helpers for the reorder buffer RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge.
`define SRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The condition must never be true at a clock edge.
`define SRB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SRB_ASSERT(lbl, prop, msg)
`define SRB_NEVER(lbl, expr, msg)
`endif
`endif

/* src/srb_pkg.sv */
`default_nettype none

package srb_pkg;

  // Window depth and the cap on resend requests per gap.
  localparam int unsigned WINDOW       = 32;
  localparam int unsigned MAX_REQUESTS = 10;
  localparam int unsigned IDX_W        = $clog2(WINDOW);

  // Field widths.
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned ACT_W  = 8;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned LEN_W  = 12;

  // Next expected number after reset and after a reset item.
  localparam logic [SEQ_W-1:0] NE_RESET = SEQ_W'(1);

  // Input item types.
  typedef enum logic [TYPE_W-1:0] {
    REQ_DATA  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_RESET = 2'd2
  } req_type_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_RESEND  = 2'd2
  } kind_e;

  // Stored descriptor of one packet.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } payload_t;

  // One window position.
  typedef struct packed {
    logic     valid;
    payload_t data;
  } entry_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/srb_in_if.sv */
`default_nettype none

interface srb_in_if;
  import srb_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [SEQ_W-1:0]   seq_num;
  logic [ACT_W-1:0]   action_code;
  logic [TAG_W-1:0]   payload_tag;
  logic [LEN_W-1:0]   payload_len;

  modport source (
    output valid, req_type, seq_num, action_code, payload_tag, payload_len,
    input  ready
  );

  modport sink (
    input  valid, req_type, seq_num, action_code, payload_tag, payload_len,
    output ready
  );
endinterface

`default_nettype wire

/* src/srb_out_if.sv */
`default_nettype none

interface srb_out_if;
  import srb_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [ACT_W-1:0]  out_action;
  logic [TAG_W-1:0]  out_tag;
  logic [LEN_W-1:0]  out_len;
  logic              end_of_message;
  logic              dropped;
  logic              last;

  modport source (
    output valid, kind, out_seq, out_action, out_tag, out_len, end_of_message,
           dropped, last,
    input  ready
  );

  modport sink (
    input  valid, kind, out_seq, out_action, out_tag, out_len, end_of_message,
           dropped, last,
    output ready
  );
endinterface

`default_nettype wire

/* src/srb_cell.sv */
`default_nettype none

// One window position. Cell k holds the packet numbered next_expected + k;
// on a shift it takes the contents of its upper neighbor.
module srb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srb_pkg::cell_ctrl_t ctrl_i,
  input  logic               wr_en_i,
  input  srb_pkg::payload_t  wr_data_i,
  input  srb_pkg::entry_t    nbr_i,
  output srb_pkg::entry_t    entry_o
);
  import srb_pkg::*;

  logic     valid_q, valid_d;
  payload_t data_q, data_d;

  // Occupancy: clear wins, then a store, then a shift from the neighbor.
  always_comb begin
    valid_d = valid_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr_en_i) begin
      valid_d = 1'b1;
    end else if (ctrl_i.shift) begin
      valid_d = nbr_i.valid;
    end
  end

  // Descriptor follows the same order; a cleared cell keeps stale data.
  always_comb begin
    data_d = data_q;
    priority if (wr_en_i) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = nbr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign entry_o = '{valid: valid_q, data: data_q};

endmodule

`default_nettype wire

/* src/sequence_reorder_buffer_unit.sv */
// Receive-side reorder buffer for one peer of a reliable datagram link.
// item_i carries data packets, ticks that re-enable resend requests, and
// reset items that empty the window. result_o carries acknowledges, in-order
// deliveries and resend requests; the last result of an item has last set.
// cfg_we_i/cfg_wdata_i write the continuation action code at any edge.
// The window is a chain of cells aligned to the next expected number; each
// delivery shifts the whole chain down by one cell.
// A data item is taken in the idle state; in the ack state its acknowledge
// is formed and loaded into the output register once that is free. Each
// delivery and each resend request then loads one further result, and at
// most MAX_REQUESTS resend requests follow a data item. Tick, reset and
// unknown items are handled in the idle state and give no result.
// A new item is taken once the last result of the previous one is in the
// output register. A stalled receiver holds the output register and the
// sequencer waits with it; nothing is dropped.
// Reset empties the window at once, sets the next expected number to one,
// enables resend requests and clears the continuation code.
`default_nettype none
`include "sequence_reorder_buffer_unit_macros.svh"

module sequence_reorder_buffer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  srb_in_if.sink                    item_i,
  srb_out_if.source                 result_o,
  input  logic                      cfg_we_i,
  input  logic [srb_pkg::ACT_W-1:0] cfg_wdata_i
);
  import srb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ACK     = 4'b0010,
    ST_RELEASE = 4'b0100,
    ST_REQUEST = 4'b1000
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [ACT_W-1:0]  action;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic              eom;
    logic              dropped;
    logic              last;
  } result_t;

  state_e             state_q, state_d;
  logic [SEQ_W-1:0]   ne_q, ne_d;
  logic               req_en_q, req_en_d;
  logic [ACT_W-1:0]   cont_q;
  logic [SEQ_W-1:0]   ack_seq_q, ack_seq_d;
  logic               ack_drop_q, ack_drop_d;
  logic [IDX_W-1:0]   req_idx_q, req_idx_d;
  logic [IDX_W-1:0]   req_idx_nxt;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               in_fire;
  logic               out_free;
  logic               load;
  logic [SEQ_W-1:0]   offset;
  logic               not_old;
  logic               in_win;
  logic               store;
  cell_ctrl_t         cell_ctrl;
  payload_t           wr_data;
  entry_t             entries [WINDOW+1];
  logic [WINDOW-1:0]  cell_valid;
  logic [WINDOW-1:0]  valid_above1;
  logic [WINDOW-1:0]  valid_above2;
  logic               any_hi;
  logic               any_hi2;

  // Input handshake: one item at a time.
  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;

  // Window check of a data packet against the next expected number.
  assign not_old = (item_i.seq_num >= ne_q);
  assign offset  = item_i.seq_num - ne_q;
  assign in_win  = not_old && (offset < SEQ_W'(WINDOW));
  assign store   = in_fire && (item_i.req_type == REQ_DATA) && in_win;
  assign wr_data = '{action: item_i.action_code, tag: item_i.payload_tag,
                     len: item_i.payload_len};

  // Chain of window cells; the cell above the top is always empty.
  assign entries[WINDOW] = '0;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    srb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .wr_en_i   (store && (offset[IDX_W-1:0] == IDX_W'(k))),
      .wr_data_i (wr_data),
      .nbr_i     (entries[k+1]),
      .entry_o   (entries[k])
    );
    assign cell_valid[k] = entries[k].valid;
  end

  // Occupancy above the head and above the cell after it.
  assign valid_above1 = cell_valid >> 1;
  assign valid_above2 = cell_valid >> 2;
  assign any_hi       = |valid_above1;
  assign any_hi2      = |valid_above2;

  assign out_free    = !out_valid_q || result_o.ready;
  assign req_idx_nxt = req_idx_q + IDX_W'(1);

  // Sequencer: acknowledge, release in order, then name the gap.
  always_comb begin
    state_d         = state_q;
    ne_d            = ne_q;
    req_en_d        = req_en_q;
    ack_seq_d       = ack_seq_q;
    ack_drop_d      = ack_drop_q;
    req_idx_d       = req_idx_q;
    load            = 1'b0;
    res_d           = res_q;
    cell_ctrl.clear = 1'b0;
    cell_ctrl.shift = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (item_i.req_type)
            REQ_DATA: begin
              ack_seq_d  = item_i.seq_num;
              ack_drop_d = not_old && !in_win;
              state_d    = ST_ACK;
            end
            REQ_TICK: begin
              req_en_d = 1'b1;
            end
            REQ_RESET: begin
              cell_ctrl.clear = 1'b1;
              ne_d            = NE_RESET;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ACK: begin
        if (out_free) begin
          load  = 1'b1;
          res_d = '{kind: KIND_ACK, seq: ack_seq_q, action: '0, tag: '0, len: '0,
                    eom: 1'b0, dropped: ack_drop_q,
                    last: !cell_valid[0] && !(any_hi && req_en_q)};
          priority if (cell_valid[0]) begin
            state_d = ST_RELEASE;
          end else if (any_hi && req_en_q) begin
            req_en_d  = 1'b0;
            req_idx_d = '0;
            state_d   = ST_REQUEST;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_RELEASE: begin
        if (out_free) begin
          load            = 1'b1;
          cell_ctrl.shift = 1'b1;
          ne_d            = ne_q + SEQ_W'(1);
          req_en_d        = 1'b1;
          res_d = '{kind: KIND_DELIVER, seq: ne_q, action: entries[0].data.action,
                    tag: entries[0].data.tag, len: entries[0].data.len,
                    eom: (entries[0].data.action != cont_q), dropped: 1'b0,
                    last: !any_hi};
          priority if (cell_valid[1]) begin
            state_d = ST_RELEASE;
          end else if (any_hi2) begin
            req_en_d  = 1'b0;
            req_idx_d = '0;
            state_d   = ST_REQUEST;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_REQUEST: begin
        if (out_free) begin
          load  = 1'b1;
          res_d = '{kind: KIND_RESEND, seq: ne_q + SEQ_W'(req_idx_q), action: '0,
                    tag: '0, len: '0, eom: 1'b0, dropped: 1'b0,
                    last: (32'(req_idx_nxt) == 32'(MAX_REQUESTS))
                          || cell_valid[req_idx_nxt]};
          req_idx_d = req_idx_nxt;
          if (res_d.last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: filled by the sequencer, emptied by the receiver.
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ne_q        <= NE_RESET;
      req_en_q    <= 1'b1;
      cont_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ne_q        <= ne_d;
      req_en_q    <= req_en_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cont_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ack_seq_q  <= ack_seq_d;
    ack_drop_q <= ack_drop_d;
    req_idx_q  <= req_idx_d;
    res_q      <= res_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.kind           = res_q.kind;
  assign result_o.out_seq        = res_q.seq;
  assign result_o.out_action     = res_q.action;
  assign result_o.out_tag        = res_q.tag;
  assign result_o.out_len        = res_q.len;
  assign result_o.end_of_message = res_q.eom;
  assign result_o.dropped        = res_q.dropped;
  assign result_o.last           = res_q.last;

  // The head cell is always drained before a new item is taken.
  `SRB_NEVER(a_idle_head_empty, (state_q == ST_IDLE) && cell_valid[0],
             "head cell still occupied while idle")
  // Requests are only named while a later packet is stored.
  `SRB_NEVER(a_request_has_gap, (state_q == ST_REQUEST) && !any_hi,
             "resend request without a stored packet above the gap")
  // Requests are disabled for the whole request burst.
  `SRB_NEVER(a_request_disabled, (state_q == ST_REQUEST) && req_en_q,
             "resend requests still enabled during a burst")
  // Each delivery advances the next expected number by exactly one.
  `SRB_ASSERT(a_release_step, (state_q == ST_RELEASE) && out_free |=>
              (ne_q == $past(ne_q) + SEQ_W'(1)), "next expected number did not advance")

endmodule

`default_nettype wire
